/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed: label");

// Property checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("check failed: label");

`endif

/* hw/rtl/mbde_pkg.sv */
`timescale 1ns / 1ps

package mbde_pkg;

    localparam int BUTTON_COUNT_DEF = 5;

    localparam int SCAN_W   = 8;
    localparam int CHANGE_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [SCAN_W-1:0]   SCAN_INTERVAL_RST = SCAN_W'(10);
    localparam logic [CHANGE_W-1:0] DEBOUNCE_TIME_RST = CHANGE_W'(30);
    localparam logic [SCAN_W-1:0]   SCAN_AGE_MAX      = {SCAN_W{1'b1}};
    localparam logic [CHANGE_W-1:0] CHANGE_AGE_MAX    = {CHANGE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 1'b1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

endpackage

/* hw/rtl/multi_button_debounce_events.sv */
`timescale 1ns / 1ps

// Debouncer for a row of active-low buttons with a sticky press-event latch.
// Input channel (i_in_valid / o_in_stall): each beat is a tick carrying the
// raw pin levels (i_cmd = tick) or a read of the event latch (i_cmd = read).
// Output channel (o_out_valid / i_out_stall): one result beat per input beat,
// in order: the event latch (before the read clears it) and the debounced
// pressed state after the beat.
// Results go to the output register, or to the skid stage while it is held.
// One beat per cycle unless stalled; all state updates in the accepting cycle.
// The output register is backed by a one-entry skid stage, so a beat is still
// taken while a result waits; o_in_stall rises only when both are full, and
// it is a registered signal.
// Configuration: write scan interval (index 0) or debounce time (index 1)
// through i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// Reset (synchronous, active low): no button pressed, latch and ages cleared,
// registers back to scan interval 10 and debounce time 30, no result pending.
module multi_button_debounce_events #(
    parameter int BUTTON_COUNT = mbde_pkg::BUTTON_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic [BUTTON_COUNT-1:0]          i_pin_levels,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [BUTTON_COUNT-1:0]          o_press_events,
    output logic [BUTTON_COUNT-1:0]          o_stable_buttons,
    input  logic                             i_cfg_we,
    input  logic [mbde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbde_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [mbde_pkg::SCAN_W-1:0]   r_scan_interval;
    logic [mbde_pkg::CHANGE_W-1:0] r_debounce_time;

    logic [BUTTON_COUNT-1:0]       r_prev_sample, n_prev_sample;
    logic [BUTTON_COUNT-1:0]       r_stable, n_stable;
    logic [BUTTON_COUNT-1:0]       r_events, n_events;
    logic [mbde_pkg::SCAN_W-1:0]   r_scan_age, n_scan_age;
    logic [mbde_pkg::CHANGE_W-1:0] r_change_age, n_change_age;

    logic [BUTTON_COUNT-1:0]       n_shown;

    logic                          r_out_valid;
    logic [BUTTON_COUNT-1:0]       r_out_events, r_out_stable;
    logic                          r_skid_valid;
    logic [BUTTON_COUNT-1:0]       r_skid_events, r_skid_stable;

    logic                          in_acc;
    logic                          out_free;
    logic [BUTTON_COUNT-1:0]       sample;
    logic                          scan_due;
    logic                          sample_diff;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    assign sample      = ~i_pin_levels;
    assign scan_due    = r_scan_age >= r_scan_interval;
    assign sample_diff = sample != r_prev_sample;

    always_comb begin
        n_prev_sample = r_prev_sample;
        n_stable      = r_stable;
        n_events      = r_events;
        n_scan_age    = r_scan_age;
        n_change_age  = r_change_age;
        n_shown       = r_events;
        if (i_cmd == mbde_pkg::CMD_READ) begin
            n_events = '0;
        end else begin
            if (scan_due) begin
                if (sample_diff) begin
                    n_prev_sample = sample;
                end else if (r_change_age >= r_debounce_time && sample != r_stable) begin
                    n_stable = sample;
                    n_events = r_events | (sample & ~r_stable);
                end
            end
            if (scan_due) begin
                n_scan_age = mbde_pkg::SCAN_W'(1);
            end else if (r_scan_age != mbde_pkg::SCAN_AGE_MAX) begin
                n_scan_age = r_scan_age + mbde_pkg::SCAN_W'(1);
            end
            if (scan_due && sample_diff) begin
                n_change_age = mbde_pkg::CHANGE_W'(1);
            end else if (r_change_age != mbde_pkg::CHANGE_AGE_MAX) begin
                n_change_age = r_change_age + mbde_pkg::CHANGE_W'(1);
            end
            n_shown = n_events;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_interval <= mbde_pkg::SCAN_INTERVAL_RST;
            r_debounce_time <= mbde_pkg::DEBOUNCE_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbde_pkg::REG_SCAN_INTERVAL: r_scan_interval <= i_cfg_data[mbde_pkg::SCAN_W-1:0];
                mbde_pkg::REG_DEBOUNCE_TIME: r_debounce_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample <= '0;
            r_stable      <= '0;
            r_events      <= '0;
            r_scan_age    <= '0;
            r_change_age  <= '0;
        end else if (in_acc) begin
            r_prev_sample <= n_prev_sample;
            r_stable      <= n_stable;
            r_events      <= n_events;
            r_scan_age    <= n_scan_age;
            r_change_age  <= n_change_age;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_events <= r_skid_events;
                r_out_stable <= r_skid_stable;
            end else if (in_acc) begin
                r_out_events <= n_shown;
                r_out_stable <= n_stable;
            end
        end else if (in_acc) begin
            r_skid_events <= n_shown;
            r_skid_stable <= n_stable;
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_press_events   = r_out_events;
    assign o_stable_buttons = r_out_stable;

endmodule

/* hw/rtl/mbde_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbde_checker #(
    parameter int BUTTON_COUNT = mbde_pkg::BUTTON_COUNT_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             i_cmd,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [BUTTON_COUNT-1:0]          o_press_events
);

    logic out_stalled;
    logic rd_beat;

    assign out_stalled = o_out_valid && i_out_stall;
    assign rd_beat = i_in_valid && !o_in_stall && (i_cmd == mbde_pkg::CMD_READ) && !out_stalled;

    `CHK_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)
    `CHK_ASSERT(a_stall_needs_result, i_clk, i_rst_n, o_in_stall |-> o_out_valid)
    `CHK_ASSERT(a_accept_gives_result, i_clk, i_rst_n, rd_beat |=> o_out_valid)
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, out_stalled |=> o_out_valid && $stable(o_press_events))

endmodule

bind multi_button_debounce_events mbde_checker #(.BUTTON_COUNT(BUTTON_COUNT)) u_mbde_checker (.*);
